// ----- rtl/core/php_pkg.sv -----
// ----------------------------------------------------------------------------
// php_pkg
// Shared types, status codes and timestamp helpers of the PES header parser.
// ----------------------------------------------------------------------------
package php_pkg;

    localparam int TS_WIDTH = 33;

    // result status codes, first error in byte order wins
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_PATTERN = 2'd1;
    localparam logic [1:0] ST_SHORT   = 2'd2;
    localparam logic [1:0] ST_MARKER  = 2'd3;

    // timestamp flag codes
    localparam logic [1:0] TSF_PTS_ONLY = 2'd2;
    localparam logic [1:0] TSF_PTS_DTS  = 2'd3;

    localparam logic [3:0] TS_GROUP_BYTES = 4'd5;

    typedef struct packed {
        logic       first_byte;
        logic [7:0] data_byte;
    } t_step;

    typedef struct packed {
        logic [7:0]          stream_code;
        logic [15:0]         packet_length;
        logic [1:0]          scrambling;
        logic [3:0]          attribute_flags;
        logic [1:0]          timestamp_flags;
        logic [5:0]          option_flags;
        logic [7:0]          header_data_length;
        logic [TS_WIDTH-1:0] pts;
        logic [TS_WIDTH-1:0] dts;
        logic [1:0]          status;
    } t_result;

    // optional bytes taken by the timestamps
    function automatic logic [3:0] ts_need(input logic [1:0] flags);
        logic [3:0] need;
        unique case (flags)
            TSF_PTS_DTS:  need = 4'd10;
            TSF_PTS_ONLY: need = TS_GROUP_BYTES;
            default:      need = 4'd0;
        endcase
        return need;
    endfunction

    // fold byte j of a five-byte timestamp group into the accumulator
    function automatic logic [TS_WIDTH-1:0] ts_fold(input logic [TS_WIDTH-1:0] acc,
                                                   input logic [2:0] j,
                                                   input logic [7:0] b);
        logic [TS_WIDTH-1:0] res;
        unique case (j)
            3'd0:    res = {b[3:1], 30'd0};
            3'd1:    res = acc | (TS_WIDTH'(b) << 22);
            3'd2:    res = acc | (TS_WIDTH'(b[7:1]) << 15);
            3'd3:    res = acc | (TS_WIDTH'(b) << 7);
            default: res = acc | TS_WIDTH'(b[7:1]);
        endcase
        return res;
    endfunction

endpackage

// ----- rtl/core/php_in_if.sv -----
// ----------------------------------------------------------------------------
// php_in_if
// Byte channel into the PES header parser.
// ----------------------------------------------------------------------------
interface php_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;

    modport source (output valid, output data_byte, output first_byte, input ready);
    modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface

// ----- rtl/core/php_out_if.sv -----
// ----------------------------------------------------------------------------
// php_out_if
// Result channel out of the PES header parser.
// ----------------------------------------------------------------------------
interface php_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  stream_code;
    logic [15:0] packet_length;
    logic [1:0]  scrambling;
    logic [3:0]  attribute_flags;
    logic [1:0]  timestamp_flags;
    logic [5:0]  option_flags;
    logic [7:0]  header_data_length;
    logic [32:0] pts;
    logic [32:0] dts;
    logic [1:0]  status;

    modport source (output valid, output stream_code, output packet_length,
                    output scrambling, output attribute_flags, output timestamp_flags,
                    output option_flags, output header_data_length, output pts,
                    output dts, output status, input ready);
    modport sink   (input valid, input stream_code, input packet_length,
                    input scrambling, input attribute_flags, input timestamp_flags,
                    input option_flags, input header_data_length, input pts,
                    input dts, input status, output ready);
endinterface

// ----- rtl/core/php_in_stage.sv -----
// ----------------------------------------------------------------------------
// php_in_stage
// Input register: holds one byte item until the parser consumes it.
// ----------------------------------------------------------------------------
module php_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  php_pkg::t_step i_step,
    output logic           o_ready,
    input  logic           i_take,
    output logic           o_valid,
    output php_pkg::t_step o_step
);

    logic           r_valid;
    php_pkg::t_step r_step;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_step  = r_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_step <= i_step;
        end
    end

endmodule

// ----- rtl/core/php_field_parser.sv -----
// ----------------------------------------------------------------------------
// php_field_parser
// Header state and the per-byte field update; flags a finished header.
// ----------------------------------------------------------------------------
module php_field_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_consume,
    input  php_pkg::t_step   i_step,
    output logic             o_emit,
    output php_pkg::t_result o_result
);

    localparam logic [8:0] POS_FLAGS1 = 9'd3;
    localparam logic [8:0] POS_HDL    = 9'd5;
    localparam logic [8:0] FIXED_LEN  = 9'd6;

    logic                         r_active, n_active;
    logic [8:0]                   r_pos, n_pos;
    logic [7:0]                   r_skip, n_skip;
    logic [47:0]                  r_store, n_store;
    logic [php_pkg::TS_WIDTH-1:0] r_pts, n_pts;
    logic [php_pkg::TS_WIDTH-1:0] r_dts, n_dts;
    logic [1:0]                   r_err, n_err;

    logic                         e_active;
    logic [8:0]                   e_pos;
    logic [7:0]                   e_skip;
    logic [47:0]                  e_store;
    logic [php_pkg::TS_WIDTH-1:0] e_pts;
    logic [php_pkg::TS_WIDTH-1:0] e_dts;
    logic [1:0]                   e_err;
    logic [8:0]                   off;
    logic [3:0]                   need;
    logic [2:0]                   ts_j;
    logic                         emit;

    always_comb begin
        // a first byte starts from a cleared state
        e_active = r_active;
        e_pos    = r_pos;
        e_skip   = r_skip;
        e_store  = r_store;
        e_pts    = r_pts;
        e_dts    = r_dts;
        e_err    = r_err;
        if (i_step.first_byte) begin
            e_active = 1'b1;
            e_pos    = '0;
            e_skip   = '0;
            e_store  = '0;
            e_pts    = '0;
            e_dts    = '0;
            e_err    = php_pkg::ST_OK;
        end

        n_active = r_active;
        n_pos    = r_pos;
        n_skip   = r_skip;
        n_store  = r_store;
        n_pts    = r_pts;
        n_dts    = r_dts;
        n_err    = r_err;
        emit     = 1'b0;
        off      = e_pos - FIXED_LEN;
        need     = '0;
        ts_j     = '0;

        if (i_consume && e_active) begin
            n_active = 1'b1;
            n_pos    = e_pos + 9'd1;
            n_skip   = e_skip;
            n_store  = e_store;
            n_pts    = e_pts;
            n_dts    = e_dts;
            n_err    = e_err;
            if (e_pos < FIXED_LEN) begin
                n_store = {e_store[39:0], i_step.data_byte};
                if (e_pos == POS_FLAGS1 && i_step.data_byte[7:6] != 2'b10
                        && n_err == php_pkg::ST_OK) begin
                    n_err = php_pkg::ST_PATTERN;
                end
                if (e_pos == POS_HDL) begin
                    // previous byte holds the timestamp flags
                    need = php_pkg::ts_need(e_store[7:6]);
                    if (i_step.data_byte < {4'd0, need}) begin
                        if (n_err == php_pkg::ST_OK) begin
                            n_err = php_pkg::ST_SHORT;
                        end
                        n_skip = {4'd0, need};
                    end else begin
                        n_skip = i_step.data_byte;
                    end
                    emit = (n_skip == 8'd0);
                end
            end else begin
                need = php_pkg::ts_need(e_store[15:14]);
                if (off < {5'd0, need}) begin
                    if (off[3:0] < php_pkg::TS_GROUP_BYTES) begin
                        ts_j  = off[2:0];
                        n_pts = php_pkg::ts_fold(e_pts, ts_j, i_step.data_byte);
                    end else begin
                        ts_j  = 3'(off[3:0] - php_pkg::TS_GROUP_BYTES);
                        n_dts = php_pkg::ts_fold(e_dts, ts_j, i_step.data_byte);
                    end
                    // marker bits sit in group bytes 0, 2 and 4
                    if (!ts_j[0] && !i_step.data_byte[0] && n_err == php_pkg::ST_OK) begin
                        n_err = php_pkg::ST_MARKER;
                    end
                end
                if (e_skip != 8'd0) begin
                    n_skip = e_skip - 8'd1;
                end
                emit = (n_skip == 8'd0);
            end
            if (emit) begin
                n_active = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_pos    <= '0;
            r_skip   <= '0;
            r_store  <= '0;
            r_pts    <= '0;
            r_dts    <= '0;
            r_err    <= php_pkg::ST_OK;
        end else begin
            r_active <= n_active;
            r_pos    <= n_pos;
            r_skip   <= n_skip;
            r_store  <= n_store;
            r_pts    <= n_pts;
            r_dts    <= n_dts;
            r_err    <= n_err;
        end
    end

    assign o_emit = emit;

    always_comb begin
        o_result.stream_code        = n_store[47:40];
        o_result.packet_length      = n_store[39:24];
        o_result.scrambling         = n_store[21:20];
        o_result.attribute_flags    = n_store[19:16];
        o_result.timestamp_flags    = n_store[15:14];
        o_result.option_flags       = n_store[13:8];
        o_result.header_data_length = n_store[7:0];
        o_result.pts                = n_pts;
        o_result.dts                = (n_store[15:14] == php_pkg::TSF_PTS_DTS) ? n_dts : '0;
        o_result.status             = n_err;
    end

endmodule

// ----- rtl/core/php_out_stage.sv -----
// ----------------------------------------------------------------------------
// php_out_stage
// Result register: holds a finished header item until the sink takes it.
// ----------------------------------------------------------------------------
module php_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  php_pkg::t_result i_result,
    output logic             o_can_take,
    input  logic             i_ready,
    output logic             o_valid,
    output php_pkg::t_result o_result
);

    logic             r_valid;
    php_pkg::t_result r_result;

    assign o_can_take = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_result   = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_take) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_take && i_valid) begin
            r_result <= i_result;
        end
    end

endmodule

// ----- rtl/core/pes_header_parser_unit.sv -----
// ----------------------------------------------------------------------------
// pes_header_parser_unit
// MPEG-2 PES header parser: one byte in per cycle, one result per header.
// ----------------------------------------------------------------------------
// Takes one header byte per clock when the result side is not stalled. Each
// byte goes through an input register, a short position-based field update and
// a result register, so a header's result is registered in the result register
// as its last byte leaves the input register. A byte marked first_byte restarts parsing; bytes
// outside a header produce nothing. While a finished result waits in the result
// register the parser holds, and the input register takes at most one more byte.
module pes_header_parser_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    php_in_if.sink    i_in,
    php_out_if.source o_out
);

    php_pkg::t_step   in_step;
    php_pkg::t_step   s1_step;
    logic             s1_valid;
    logic             s1_take;
    logic             emit;
    php_pkg::t_result parse_res;
    php_pkg::t_result out_res;
    logic             out_valid;

    assign in_step.first_byte = i_in.first_byte;
    assign in_step.data_byte  = i_in.data_byte;

    php_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_step  (in_step),
        .o_ready (i_in.ready),
        .i_take  (s1_take),
        .o_valid (s1_valid),
        .o_step  (s1_step)
    );

    php_field_parser u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_consume (s1_valid && s1_take),
        .i_step    (s1_step),
        .o_emit    (emit),
        .o_result  (parse_res)
    );

    php_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s1_valid && emit),
        .i_result   (parse_res),
        .o_can_take (s1_take),
        .i_ready    (o_out.ready),
        .o_valid    (out_valid),
        .o_result   (out_res)
    );

    assign o_out.valid              = out_valid;
    assign o_out.stream_code        = out_res.stream_code;
    assign o_out.packet_length      = out_res.packet_length;
    assign o_out.scrambling         = out_res.scrambling;
    assign o_out.attribute_flags    = out_res.attribute_flags;
    assign o_out.timestamp_flags    = out_res.timestamp_flags;
    assign o_out.option_flags       = out_res.option_flags;
    assign o_out.header_data_length = out_res.header_data_length;
    assign o_out.pts                = out_res.pts;
    assign o_out.dts                = out_res.dts;
    assign o_out.status             = out_res.status;

endmodule

// ----- rtl/core/php_checker.sv -----
// ----------------------------------------------------------------------------
// php_checker
// Port-level checks of the PES header parser, bound to the top level.
// ----------------------------------------------------------------------------
module php_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_ts_flags,
    input logic [7:0]  i_hdl,
    input logic [32:0] i_pts,
    input logic [32:0] i_dts,
    input logic [1:0]  i_status
);

    // a stalled result stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result offered right after reset");

    a_dts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_ts_flags != php_pkg::TSF_PTS_DTS |-> i_dts == '0)
        else $error("dts reported without dts flag");

    a_pts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_ts_flags[1] |-> i_pts == '0)
        else $error("pts reported without pts flag");

    a_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == php_pkg::ST_SHORT |-> i_ts_flags[1] && i_hdl < 8'd10)
        else $error("short header status on a header long enough");

endmodule

bind pes_header_parser_unit php_checker u_php_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_ts_flags  (o_out.timestamp_flags),
    .i_hdl       (o_out.header_data_length),
    .i_pts       (o_out.pts),
    .i_dts       (o_out.dts),
    .i_status    (o_out.status)
);

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the PES header parser. Header byte streams (directed
// corner cases, then mostly well-formed random headers mixed with noise and
// truncated headers) go in with random gaps while the result side stalls at
// random. An in-bench parser predicts each header result, and every result
// is checked field by field in order.
// ----------------------------------------------------------------------------
module tb;

    localparam int RAND_ITEMS = 640;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 16;

    localparam logic [1:0] TSF_NONE     = 2'd0;
    localparam logic [1:0] TSF_RESERVED = 2'd1;
    localparam logic [1:0] FLAG_MARK    = 2'b10;

    logic i_clk;
    logic i_rst_n;

    php_in_if  in_if ();
    php_out_if out_if ();

    pes_header_parser_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    php_pkg::t_step   byte_q[$];
    php_pkg::t_result exp_results[$];

    int fail_cnt = 0;
    int bytes_accepted = 0;
    int n_total = 0;
    int cycle_cnt = 0;

    logic byte_taken = 1'b0;
    logic result_taken = 1'b0;
    int   gap_left = 0;
    int   stall_left = 0;
    bit   in_burst = 1'b0;
    bit   out_burst = 1'b0;

    // parser state kept by the bench
    logic        hdr_open = 1'b0;
    logic [8:0]  hdr_pos = '0;
    logic [7:0]  opt_left = '0;
    logic [47:0] hdr_fields = '0;
    logic [32:0] pts_acc = '0;
    logic [32:0] dts_acc = '0;
    logic [1:0]  hdr_status = php_pkg::ST_OK;

    function automatic logic [3:0] ts_byte_count(input logic [1:0] flags);
        case (flags)
            php_pkg::TSF_PTS_DTS:  return 4'd10;
            php_pkg::TSF_PTS_ONLY: return 4'd5;
            default:               return 4'd0;
        endcase
    endfunction

    // first error in byte order sticks
    function automatic void note_status(input logic [1:0] code);
        if (hdr_status == php_pkg::ST_OK) hdr_status = code;
    endfunction

    function automatic logic [32:0] fold_ts_byte(input logic [32:0] acc, input int j,
                                                 input logic [7:0] b);
        logic [32:0] r;
        r = acc;
        case (j)
            0:       r = {b[3:1], 30'd0};
            1:       r[29:22] = b;
            2:       r[21:15] = b[7:1];
            3:       r[14:7] = b;
            default: r[6:0] = b[7:1];
        endcase
        if ((j == 0 || j == 2 || j == 4) && !b[0]) note_status(php_pkg::ST_MARKER);
        return r;
    endfunction

    function automatic php_pkg::t_result close_header();
        php_pkg::t_result r;
        r.stream_code        = hdr_fields[47:40];
        r.packet_length      = hdr_fields[39:24];
        r.scrambling         = hdr_fields[21:20];
        r.attribute_flags    = hdr_fields[19:16];
        r.timestamp_flags    = hdr_fields[15:14];
        r.option_flags       = hdr_fields[13:8];
        r.header_data_length = hdr_fields[7:0];
        r.pts                = pts_acc;
        r.dts                = (hdr_fields[15:14] == php_pkg::TSF_PTS_DTS) ? dts_acc : '0;
        r.status             = hdr_status;
        hdr_open = 1'b0;
        return r;
    endfunction

    function automatic bit parse_pes_byte(input logic [7:0] b, input logic fb,
                                          output php_pkg::t_result res);
        logic [8:0] pos;
        logic [8:0] off;
        logic [8:0] need;
        res = '0;
        if (fb) begin
            hdr_open   = 1'b1;
            hdr_pos    = '0;
            opt_left   = '0;
            hdr_fields = '0;
            pts_acc    = '0;
            dts_acc    = '0;
            hdr_status = php_pkg::ST_OK;
        end else if (!hdr_open) begin
            return 1'b0;
        end
        pos = hdr_pos;
        hdr_pos = pos + 9'd1;
        if (pos < 9'd6) begin
            hdr_fields = {hdr_fields[39:0], b};
            if (pos == 9'd3 && b[7:6] != FLAG_MARK) note_status(php_pkg::ST_PATTERN);
            if (pos != 9'd5) return 1'b0;
            // timestamps are read even when the length byte is too small
            need = 9'(ts_byte_count(hdr_fields[15:14]));
            if (9'(b) < need) begin
                note_status(php_pkg::ST_SHORT);
                opt_left = 8'(need);
            end else begin
                opt_left = b;
            end
        end else begin
            off = pos - 9'd6;
            need = 9'(ts_byte_count(hdr_fields[15:14]));
            if (off < need) begin
                if (off < 9'd5) pts_acc = fold_ts_byte(pts_acc, int'(off), b);
                else            dts_acc = fold_ts_byte(dts_acc, int'(off) - 5, b);
            end
            if (opt_left != 8'd0) opt_left = opt_left - 8'd1;
        end
        if (opt_left != 8'd0) return 1'b0;
        res = close_header();
        return 1'b1;
    endfunction

    function automatic logic [32:0] rand_ts();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return 33'({$urandom(), $urandom()});
        endcase
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic fb);
        php_pkg::t_step s;
        s.first_byte = fb;
        s.data_byte  = b;
        byte_q.push_back(s);
    endtask

    // bad_marks: three marker bits per timestamp group, PTS group in [2:0]
    // cut: number of bytes sent before the header is abandoned, 0 for all
    task automatic add_header(input logic [7:0] sid, input logic [15:0] plen,
                              input logic [7:0] flags1, input logic [7:0] flags2,
                              input logic [7:0] hdl, input logic [32:0] pts,
                              input logic [32:0] dts, input logic [5:0] bad_marks,
                              input int tail, input int cut);
        logic [7:0]  hb[$];
        logic [32:0] ts;
        logic [2:0]  m;
        logic [3:0]  pfx;
        int          n_ts;
        int          n_opt;
        int          lim;
        n_ts = int'(ts_byte_count(flags2[7:6]));
        n_opt = (int'(hdl) < n_ts) ? n_ts : int'(hdl);
        hb.push_back(sid);
        hb.push_back(plen[15:8]);
        hb.push_back(plen[7:0]);
        hb.push_back(flags1);
        hb.push_back(flags2);
        hb.push_back(hdl);
        for (int g = 0; g < n_ts / 5; g++) begin
            ts  = (g == 0) ? pts : dts;
            m   = bad_marks[g*3 +: 3];
            pfx = 4'($urandom());
            hb.push_back({pfx, ts[32:30], ~m[0]});
            hb.push_back(ts[29:22]);
            hb.push_back({ts[21:15], ~m[1]});
            hb.push_back(ts[14:7]);
            hb.push_back({ts[6:0], ~m[2]});
        end
        while (hb.size() < 6 + n_opt) hb.push_back(8'($urandom()));
        repeat (tail) hb.push_back(8'($urandom()));
        lim = (cut > 0 && cut < hb.size()) ? cut : hb.size();
        for (int i = 0; i < lim; i++) push_byte(hb[i], i == 0);
    endtask

    task automatic check_field(input string name, input logic [32:0] want,
                               input logic [32:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_cnt++;
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("pes_header_parser_unit test failed");
            $finish;
        end
    end

    // byte source
    always @(negedge i_clk) begin : drive_bytes
        php_pkg::t_step nxt;
        if (!i_rst_n) begin
            in_if.valid = 1'b0;
        end else if (!in_if.valid || byte_taken) begin
            if (gap_left > 0) begin
                in_if.valid = 1'b0;
                gap_left--;
            end else if (byte_q.size() > 0) begin
                nxt = byte_q.pop_front();
                in_if.data_byte  = nxt.data_byte;
                in_if.first_byte = nxt.first_byte;
                in_if.valid      = 1'b1;
                if ($urandom_range(0, 49) == 0) in_burst = !in_burst;
                gap_left = in_burst ? 0 : $urandom_range(0, 4);
            end else begin
                in_if.valid = 1'b0;
            end
        end
    end

    // result sink
    always @(negedge i_clk) begin : drive_ready
        if (!i_rst_n) begin
            out_if.ready = 1'b0;
        end else begin
            if (result_taken) begin
                if ($urandom_range(0, 15) == 0) out_burst = !out_burst;
                stall_left = out_burst ? 0 : $urandom_range(0, 4);
            end
            if (stall_left > 0) begin
                out_if.ready = 1'b0;
                stall_left--;
            end else begin
                out_if.ready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : watch
        php_pkg::t_result want;
        php_pkg::t_result pred;
        if (!i_rst_n) begin
            byte_taken   <= 1'b0;
            result_taken <= 1'b0;
        end else begin
            byte_taken   <= in_if.valid && in_if.ready;
            result_taken <= out_if.valid && out_if.ready;
            if (out_if.valid && out_if.ready) begin
                if (exp_results.size() == 0) begin
                    $error("unexpected result: stream_code 0x%0h", out_if.stream_code);
                    fail_cnt++;
                end else begin
                    want = exp_results.pop_front();
                    check_field("stream_code", 33'(want.stream_code),
                                33'(out_if.stream_code));
                    check_field("packet_length", 33'(want.packet_length),
                                33'(out_if.packet_length));
                    check_field("scrambling", 33'(want.scrambling), 33'(out_if.scrambling));
                    check_field("attribute_flags", 33'(want.attribute_flags),
                                33'(out_if.attribute_flags));
                    check_field("timestamp_flags", 33'(want.timestamp_flags),
                                33'(out_if.timestamp_flags));
                    check_field("option_flags", 33'(want.option_flags),
                                33'(out_if.option_flags));
                    check_field("header_data_length", 33'(want.header_data_length),
                                33'(out_if.header_data_length));
                    check_field("pts", want.pts, out_if.pts);
                    check_field("dts", want.dts, out_if.dts);
                    check_field("status", 33'(want.status), 33'(out_if.status));
                end
            end
            if (in_if.valid && in_if.ready) begin
                bytes_accepted++;
                if (parse_pes_byte(in_if.data_byte, in_if.first_byte, pred))
                    exp_results.push_back(pred);
            end
        end
    end

    initial begin : main
        int          n_goal;
        int          kind;
        int          need;
        int          r;
        logic [7:0]  fl1;
        logic [7:0]  fl2;
        logic [7:0]  hdl;
        logic [5:0]  bad;

        in_if.valid      = 1'b0;
        in_if.data_byte  = '0;
        in_if.first_byte = 1'b0;
        out_if.ready     = 1'b0;
        i_rst_n          = 1'b0;

        // stray bytes before any header
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h47, 1'b0);
        // no optional bytes: result on the length byte itself
        add_header(8'hE0, 16'h0000, {FLAG_MARK, 6'h00}, {TSF_NONE, 6'h00}, 8'd0,
                   '0, '0, 6'd0, 0, 0);
        add_header(8'hFF, 16'hFFFF, {FLAG_MARK, 6'h3F}, {TSF_NONE, 6'h3F}, 8'd3,
                   '0, '0, 6'd0, 1, 0);
        add_header(8'hC0, 16'h1234, {FLAG_MARK, 6'h15}, {php_pkg::TSF_PTS_ONLY, 6'h2A},
                   8'd5, '1, '0, 6'd0, 2, 0);
        add_header(8'hBD, 16'h8000, {FLAG_MARK, 6'h2A}, {php_pkg::TSF_PTS_DTS, 6'h15},
                   8'd10, '0, '1, 6'd0, 0, 0);
        // flags value 1 reads no timestamp
        add_header(8'hE1, 16'h00FF, {FLAG_MARK, 6'h00}, {TSF_RESERVED, 6'h00}, 8'd2,
                   '1, '1, 6'd0, 0, 0);
        // bad pattern ahead of a marker error
        add_header(8'hE2, 16'h0102, {2'b01, 6'h3F}, {php_pkg::TSF_PTS_ONLY, 6'h00}, 8'd5,
                   rand_ts(), '0, 6'b000_010, 0, 0);
        add_header(8'hE3, 16'h0203, {2'b11, 6'h00}, {TSF_NONE, 6'h00}, 8'd1,
                   '0, '0, 6'd0, 0, 0);
        add_header(8'hE4, 16'h0304, {2'b00, 6'h00}, {TSF_NONE, 6'h00}, 8'd0,
                   '0, '0, 6'd0, 0, 0);
        // too short for both stamps, markers also broken
        add_header(8'hE5, 16'h0405, {FLAG_MARK, 6'h00}, {php_pkg::TSF_PTS_DTS, 6'h00}, 8'd4,
                   rand_ts(), rand_ts(), 6'b100_001, 1, 0);
        add_header(8'hE6, 16'h0506, {FLAG_MARK, 6'h00}, {php_pkg::TSF_PTS_ONLY, 6'h00}, 8'd0,
                   rand_ts(), '0, 6'd0, 0, 0);
        // marker errors, first one in the DTS group, then all of them
        add_header(8'hE7, 16'h0607, {FLAG_MARK, 6'h00}, {php_pkg::TSF_PTS_DTS, 6'h00}, 8'd12,
                   rand_ts(), rand_ts(), 6'b010_000, 0, 0);
        add_header(8'hE8, 16'h0708, {FLAG_MARK, 6'h00}, {php_pkg::TSF_PTS_DTS, 6'h00}, 8'd10,
                   rand_ts(), rand_ts(), 6'b111_111, 0, 0);
        // new header starts mid-header
        add_header(8'hE9, 16'h0809, {FLAG_MARK, 6'h00}, {php_pkg::TSF_PTS_DTS, 6'h00}, 8'd10,
                   rand_ts(), rand_ts(), 6'd0, 0, 9);
        add_header(8'hEA, 16'h090A, {FLAG_MARK, 6'h00}, {TSF_NONE, 6'h00}, 8'd4,
                   '0, '0, 6'd0, 0, 2);
        add_header(8'hEB, 16'h0A0B, {FLAG_MARK, 6'h00}, {php_pkg::TSF_PTS_DTS, 6'h00},
                   8'd255, rand_ts(), rand_ts(), 6'd0, 2, 0);

        n_goal = byte_q.size() + RAND_ITEMS;
        while (byte_q.size() < n_goal) begin
            kind = $urandom_range(0, 19);
            if (kind < 2) begin
                repeat ($urandom_range(1, 4))
                    push_byte(8'($urandom()), $urandom_range(0, 3) == 0);
            end else begin
                fl1 = 8'($urandom());
                if ($urandom_range(0, 9) != 0) fl1[7:6] = FLAG_MARK;
                fl2 = 8'($urandom());
                need = int'(ts_byte_count(fl2[7:6]));
                r = $urandom_range(0, 19);
                if (r == 0)
                    hdl = 8'($urandom());
                else if (r < 3)
                    hdl = 8'((need > 0) ? $urandom_range(0, need - 1) : $urandom_range(0, 3));
                else
                    hdl = 8'(need + $urandom_range(0, 5));
                bad = '0;
                if ($urandom_range(0, 9) == 0) bad = 6'($urandom());
                add_header(8'($urandom()), 16'($urandom()), fl1, fl2, hdl,
                           rand_ts(), rand_ts(), bad, $urandom_range(0, 3),
                           (kind < 4) ? $urandom_range(1, 6 + need + 2) : 0);
            end
        end
        n_total = byte_q.size();

        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        wait (bytes_accepted == n_total);
        wait (exp_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("pes_header_parser_unit test passed");
        end else begin
            $display("pes_header_parser_unit test failed");
        end
        $finish;
    end

endmodule
